@@ design/hfa_pkg.sv @@
// Package for the half-precision arithmetic unit: command codes, compare codes
// and binary16 constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hfa_pkg;
    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_MUL2 = 3'd1,
        CMD_DIV2 = 3'd2,
        CMD_NEG  = 3'd3,
        CMD_CMP  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ORD_LESS  = 2'd0,
        ORD_EQUAL = 2'd1,
        ORD_GREATER = 2'd2,
        ORD_UNORDERED = 2'd3
    } t_order;

    localparam logic [15:0] SIGN_BIT  = 16'h8000;
    localparam logic [15:0] EXP_MASK  = 16'h7C00;
    localparam logic [15:0] MANT_MASK = 16'h03FF;
    localparam logic [15:0] MAG_MASK  = 16'h7FFF;
    localparam logic [15:0] QNAN      = 16'h7E00;
    localparam logic [4:0]  EXP_MAX   = 5'h1F;
endpackage
`default_nettype wire

@@ design/half_float_alu_core.sv @@
// Top level of the half-precision arithmetic unit: input register, one pass of
// add / scale / negate / compare logic, result register. Depends on hfa_pkg.
//
// Usage: the input channel (i_valid / o_ready) carries one word of command and
// two binary16 operands; the output channel (o_valid / i_ready) returns one
// word holding the binary16 value and a two-bit compare code.
// A word accepted at a clock edge sits in the input register, the arithmetic
// runs combinationally from it, and the result is loaded into the result
// register, from which it appears on the output ports.
// Throughput is one word per cycle while the receiver takes every result. Both
// stages advance together whenever the result register is empty or being
// drained, so a full pipe keeps flowing at one word per clock with no bubbles.
// When the receiver stalls, the result register holds its word and the input
// stage holds too; o_ready falls only when both stages are full and the
// output is not taken. Nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties both stages; payload registers
// are not cleared. The unit keeps no state between words.
// The critical path is the adder: alignment shift, 41-bit add, leading-one
// search over the sum and the normalizing shift.
`timescale 1ns / 1ps
`default_nettype none
module half_float_alu_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_operand_a,
    input  wire logic [15:0] i_operand_b,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_value,
    output logic [1:0]       o_order_code
);
    import hfa_pkg::*;

    logic        r_in_valid, r_out_valid;
    logic [2:0]  r_cmd;
    logic [15:0] r_a, r_b;
    logic [15:0] r_value;
    logic [1:0]  r_code;
    logic        advance;
    logic [15:0] n_value;
    logic [1:0]  n_code;

    // The execute stage moves when the result register can take a word.
    assign advance = !r_out_valid || i_ready;
    assign o_ready = advance || !r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= i_command;
            r_a   <= i_operand_a;
            r_b   <= i_operand_b;
        end
        if (advance && r_in_valid) begin
            r_value <= n_value;
            r_code  <= n_code;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value      = r_value;
    assign o_order_code = r_code;

    // ---------------- Operand decode ----------------
    logic [4:0]  ea, eb;
    logic        sa, sb, nan_a, nan_b, inf_a, inf_b;
    assign sa = r_a[15];
    assign sb = r_b[15];
    assign ea = r_a[14:10];
    assign eb = r_b[14:10];
    assign nan_a = (r_a & MAG_MASK) > EXP_MASK;
    assign nan_b = (r_b & MAG_MASK) > EXP_MASK;
    assign inf_a = (r_a & MAG_MASK) == EXP_MASK;
    assign inf_b = (r_b & MAG_MASK) == EXP_MASK;

    // ---------------- Adder ----------------
    // Each operand becomes an 11-bit significand with an effective exponent
    // (subnormals use exponent one). The larger magnitude is the anchor; the
    // smaller is shifted right with none of its bits lost, because truncation
    // of the exact result needs the exact difference. A 29-bit extension
    // below the significand covers the widest possible exponent gap.
    logic [4:0]  eea, eeb, e_big, e_sml;
    logic [10:0] ma, mb, m_big, m_sml;
    logic        s_big, swap;
    logic [4:0]  dexp;
    logic [40:0] big_w, sml_w, sum_w;
    logic        eff_sub;
    logic [5:0]  lead;
    logic [15:0] add_res;
    logic [40:0] norm;
    logic [6:0]  e_sum, e_res;

    assign eea = (ea == 5'd0) ? 5'd1 : ea;
    assign eeb = (eb == 5'd0) ? 5'd1 : eb;
    assign ma  = {(ea != 5'd0), r_a[9:0]};
    assign mb  = {(eb != 5'd0), r_b[9:0]};
    assign swap  = (r_b[14:0] > r_a[14:0]);
    assign e_big = swap ? eeb : eea;
    assign e_sml = swap ? eea : eeb;
    assign m_big = swap ? mb : ma;
    assign m_sml = swap ? ma : mb;
    assign s_big = swap ? sb : sa;
    assign dexp  = e_big - e_sml;
    assign eff_sub = sa ^ sb;
    // Significands sit at bits [39:29]; bit 40 takes the carry. A shift of
    // up to 29 places keeps every bit of the smaller operand exact.
    assign big_w = {1'b0, m_big, 29'd0};
    assign sml_w = ({1'b0, m_sml, 29'd0}) >> dexp;
    assign sum_w = eff_sub ? (big_w - sml_w) : (big_w + sml_w);

    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < 41; i++) begin
            if (sum_w[i]) begin
                lead = 6'(i);
            end
        end
    end

    assign e_sum = {2'b0, e_big} + {1'b0, lead};

    // Leading one at bit 39 means exponent e_big. Result exponent is
    // e_big + lead - 39; below one the value is subnormal.
    always_comb begin
        add_res = 16'd0;
        norm    = 41'd0;
        e_res   = 7'd0;
        if (nan_a || nan_b) begin
            add_res = QNAN;
        end else if (inf_a && inf_b) begin
            add_res = (sa == sb) ? r_a : QNAN;
        end else if (inf_a) begin
            add_res = r_a;
        end else if (inf_b) begin
            add_res = r_b;
        end else if (sum_w == 41'd0) begin
            add_res = {sa & sb, 15'd0};
        end else if (e_sum > 7'd39) begin
            e_res = e_sum - 7'd39;
            norm  = sum_w >> (lead - 6'd10);
            if (e_res >= {2'b0, EXP_MAX}) begin
                add_res = {s_big, EXP_MASK[14:0]};
            end else begin
                add_res = {s_big, e_res[4:0], norm[9:0]};
            end
        end else begin
            // Subnormal: the value in units of the smallest subnormal is
            // sum_w shifted right by 30 - e_big.
            norm    = sum_w >> (6'd30 - {1'b0, e_big});
            add_res = {s_big, norm[14:0]};
        end
    end

    // ---------------- Scaling ----------------
    logic [15:0] mul_res, div_res;
    logic [4:0]  ea_p1, ea_m1;
    assign ea_p1 = ea + 5'd1;
    assign ea_m1 = ea - 5'd1;

    always_comb begin
        if (ea == EXP_MAX) begin
            mul_res = r_a;
        end else if (ea == 5'd0) begin
            mul_res = {sa, r_a[13:0], 1'b0};
        end else if (ea_p1 == EXP_MAX) begin
            mul_res = {sa, EXP_MASK[14:0]};
        end else begin
            mul_res = {sa, ea_p1, r_a[9:0]};
        end
    end

    always_comb begin
        if (ea == EXP_MAX) begin
            div_res = r_a;
        end else if (ea <= 5'd1) begin
            div_res = {sa, 1'b0, r_a[14:1]};
        end else begin
            div_res = {sa, ea_m1, r_a[9:0]};
        end
    end

    // ---------------- Compare ----------------
    logic [16:0] ka, kb;
    logic [1:0]  cmp_res;
    assign ka = sa ? (17'h08000 - {2'b0, r_a[14:0]}) : (17'h08000 + {2'b0, r_a[14:0]});
    assign kb = sb ? (17'h08000 - {2'b0, r_b[14:0]}) : (17'h08000 + {2'b0, r_b[14:0]});
    always_comb begin
        if (nan_a || nan_b) begin
            cmp_res = ORD_UNORDERED;
        end else if (ka < kb) begin
            cmp_res = ORD_LESS;
        end else if (ka == kb) begin
            cmp_res = ORD_EQUAL;
        end else begin
            cmp_res = ORD_GREATER;
        end
    end

    // ---------------- Result select ----------------
    always_comb begin
        n_value = 16'd0;
        n_code  = 2'd0;
        unique case (r_cmd)
            CMD_ADD:  n_value = add_res;
            CMD_MUL2: n_value = mul_res;
            CMD_DIV2: n_value = div_res;
            CMD_NEG:  n_value = r_a ^ SIGN_BIT;
            CMD_CMP:  n_code  = cmp_res;
            default: begin
                n_value = 16'd0;
                n_code  = 2'd0;
            end
        endcase
    end

    // ---------------- Assertions ----------------
    a_code_only_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && r_cmd != CMD_CMP) |=> (r_code == 2'd0))
        else $error("order code set for a non-compare command");
    a_value_zero_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && r_cmd == CMD_CMP) |=> (r_value == 16'd0))
        else $error("value not zero for compare");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_value)))
        else $error("result changed while stalled");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid || !r_out_valid) |-> o_ready)
        else $error("ready low with room in the pipe");
endmodule
`default_nettype wire

@@ tb/sv/hfa_checker.sv @@
// Checker for the half-precision arithmetic unit: watches both channels,
// predicts each result word and compares it. Depends on hfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hfa_checker
    import hfa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_in_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_operand_a,
    input  wire logic [15:0] i_operand_b,
    input  wire logic        i_out_valid,
    input  wire logic        i_ready,
    input  wire logic [15:0] i_value,
    input  wire logic [1:0]  i_order_code,
    output int               o_errors,
    output int               o_pending,
    output int               o_results
);
    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  order;
    } t_result;

    t_result expected_q[$];

    function automatic logic is_nan(logic [15:0] h);
        return (h & MAG_MASK) > EXP_MASK;
    endfunction

    function automatic logic is_inf(logic [15:0] h);
        return (h & MAG_MASK) == EXP_MASK;
    endfunction

    // Magnitude in units of the smallest subnormal.
    function automatic logic [40:0] mag_units(logic [15:0] h);
        logic [4:0] e;
        e = h[14:10];
        if (e == 0) return {31'd0, h[9:0]};
        return {30'd0, 1'b1, h[9:0]} << (e - 1);
    endfunction

    function automatic logic [15:0] pack_trunc(logic [40:0] mag, logic sgn);
        int p;
        logic [40:0] m;
        p = 0;
        if (mag < 41'h400) return {sgn, mag[14:0]};
        for (int i = 0; i < 41; i++) if (mag[i]) p = i;
        if (p - 9 >= 31) return {sgn, EXP_MASK[14:0]};
        m = mag >> (p - 10);
        return {sgn, 5'(p - 9), m[9:0]};
    endfunction

    function automatic logic [15:0] half_sum(logic [15:0] a, logic [15:0] b);
        logic [40:0] ma, mb;
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (is_inf(a) && is_inf(b)) return (a[15] == b[15]) ? a : QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        ma = mag_units(a);
        mb = mag_units(b);
        if (a[15] == b[15]) return pack_trunc(ma + mb, a[15]);
        if (ma > mb) return pack_trunc(ma - mb, a[15]);
        if (mb > ma) return pack_trunc(mb - ma, b[15]);
        return 16'h0000;
    endfunction

    function automatic logic [15:0] half_double(logic [15:0] a);
        logic [4:0] e;
        e = a[14:10];
        if (e == EXP_MAX) return a;
        if (e == 0) return {a[15], a[13:0], 1'b0};
        if (e + 5'd1 == EXP_MAX) return {a[15], EXP_MASK[14:0]};
        return {a[15], e + 5'd1, a[9:0]};
    endfunction

    function automatic logic [15:0] half_halve(logic [15:0] a);
        logic [4:0] e;
        e = a[14:10];
        if (e == EXP_MAX) return a;
        if (e <= 1) return {a[15], 1'b0, a[14:1]};
        return {a[15], e - 5'd1, a[9:0]};
    endfunction

    function automatic t_order half_order(logic [15:0] a, logic [15:0] b);
        logic [16:0] ka, kb;
        if (is_nan(a) || is_nan(b)) return ORD_UNORDERED;
        ka = a[15] ? 17'h8000 - a[14:0] : 17'h8000 + a[14:0];
        kb = b[15] ? 17'h8000 - b[14:0] : 17'h8000 + b[14:0];
        if (ka < kb) return ORD_LESS;
        if (ka == kb) return ORD_EQUAL;
        return ORD_GREATER;
    endfunction

    function automatic t_result predict_result(logic [2:0] cmd, logic [15:0] a,
                                               logic [15:0] b);
        t_result r;
        r = '0;
        case (cmd)
            CMD_ADD:  r.value = half_sum(a, b);
            CMD_MUL2: r.value = half_double(a);
            CMD_DIV2: r.value = half_halve(a);
            CMD_NEG:  r.value = a ^ SIGN_BIT;
            CMD_CMP:  r.order = half_order(a, b);
            default:  r = '0;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            expected_q.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_valid && i_in_ready)
                expected_q.push_back(predict_result(i_command, i_operand_a, i_operand_b));
            if (i_out_valid && i_ready) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("ERROR: result word %h/%0d with nothing expected",
                                 i_value, i_order_code);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.value !== i_value || want.order !== i_order_code) begin
                        if (o_errors < 10)
                            $display("ERROR: expected value %h order %0d, got %h %0d",
                                     want.value, want.order, i_value, i_order_code);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_q.size();
endmodule
`default_nettype wire

@@ tb/sv/tb_half_float_alu_core.sv @@
// Testbench top for half_float_alu_core: drives command words, stalls the
// result side and gives the verdict. Depends on hfa_pkg and hfa_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_half_float_alu_core;
    import hfa_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  command = CMD_ADD;
    logic [15:0] operand_a = '0;
    logic [15:0] operand_b = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] value;
    logic [1:0]  order_code;
    int          errors, pending, results;
    int          send_idle = 12, recv_idle = 76;
    logic        hold_off = 1'b0;
    int          cycles = 0;

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    half_float_alu_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_command(command), .i_operand_a(operand_a), .i_operand_b(operand_b),
        .o_valid(out_valid), .i_ready(out_ready), .o_value(value),
        .o_order_code(order_code)
    );

    hfa_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_ready(in_ready),
        .i_command(command), .i_operand_a(operand_a), .i_operand_b(operand_b),
        .i_out_valid(out_valid), .i_ready(out_ready), .i_value(value),
        .i_order_code(order_code), .o_errors(errors), .o_pending(pending),
        .o_results(results)
    );

    // The receiver takes a word with a random chance, unless held off.
    always @(posedge clk) begin
        out_ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: the slowest correct run is far below this.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("half_float_alu_core: mismatch");
            $finish;
        end
    end

    // Pick an operand that leans on the interesting classes of binary16.
    function automatic logic [15:0] pick_half();
        logic s;
        s = 1'($urandom_range(1));
        case ($urandom_range(9))
            0:       return {s, 15'h0000};
            1:       return {s, 5'd0, 10'($urandom)};
            2:       return {s, EXP_MASK[14:0]};
            3:       return {s, 5'h1F, 10'($urandom_range(1023, 1))};
            4:       return {s, 5'd1, 10'($urandom)};
            5:       return {s, 5'h1E, 10'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one word and hold it until it is taken. Valid drops only when
    // the sender idles before the next word.
    task automatic send_word(logic [2:0] cmd, logic [15:0] a, logic [15:0] b);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [2:0] cmd;
        logic [15:0] a;
        for (int i = 0; i < count; i++) begin
            cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                            : 3'($urandom_range(4));
            a = pick_half();
            // Sometimes compare or add a value with itself or its negation.
            if ($urandom_range(7) == 0)
                send_word(cmd, a, a ^ ({15'd0, 1'($urandom)} << 15));
            else
                send_word(cmd, a, pick_half());
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: corners of each command.
        send_word(CMD_ADD, 16'h7E00, 16'h3C00);        // NaN input
        send_word(CMD_ADD, 16'h7C00, 16'hFC00);        // infinity minus infinity
        send_word(CMD_ADD, 16'hFC00, 16'hFC00);        // same infinity
        send_word(CMD_ADD, 16'h7C00, 16'h3C00);        // infinity plus finite
        send_word(CMD_ADD, 16'h3C00, 16'hBC00);        // exact zero
        send_word(CMD_ADD, 16'h8000, 16'h8000);        // minus zero sum
        send_word(CMD_ADD, 16'h7BFF, 16'h7BFF);        // overflow
        send_word(CMD_ADD, 16'h03FF, 16'h0001);        // subnormal into normal
        send_word(CMD_ADD, 16'h3C00, 16'h0001);        // truncated tiny addend
        send_word(CMD_ADD, 16'h7800, 16'h8001);        // widest gap, borrow
        send_word(CMD_ADD, 16'hFFFF, 16'h0000);
        send_word(CMD_MUL2, 16'h7BFF, 16'h0000);       // overflow to infinity
        send_word(CMD_MUL2, 16'h83FF, 16'h0000);       // subnormal carries
        send_word(CMD_MUL2, 16'hFE01, 16'h0000);       // NaN unchanged
        send_word(CMD_DIV2, 16'h0401, 16'h0000);       // smallest normal exponent
        send_word(CMD_DIV2, 16'h8001, 16'h0000);       // lost bit
        send_word(CMD_DIV2, 16'hFC00, 16'hFFFF);       // infinity unchanged
        send_word(CMD_NEG, 16'h7E00, 16'h0000);
        send_word(CMD_NEG, 16'h0000, 16'hFFFF);
        send_word(CMD_CMP, 16'h0000, 16'h8000);        // zeros equal
        send_word(CMD_CMP, 16'h7C01, 16'h0000);        // unordered
        send_word(CMD_CMP, 16'hBC00, 16'h3C00);
        send_word(CMD_CMP, 16'hBC00, 16'hC000);
        send_word(CMD_CMP, 16'h7C00, 16'h7BFF);
        send_word(3'd7, 16'hFFFF, 16'hFFFF);           // unused command

        send_random(500);

        // Long receiver stall while words keep coming, so the pipe backs up.
        hold_off <= 1'b1;
        fork
            begin
                repeat (60) @(posedge clk);
                hold_off <= 1'b0;
            end
            send_random(20);
        join

        send_idle = 76;
        recv_idle = 12;
        send_random(580);
        send_idle = 0;
        recv_idle = 0;
        send_random(580);
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Ran %0d result words over add, scaling, negate, compare and unused codes,",
                 results);
        $display("with sender and receiver stalls and a long receiver hold-off.");
        if (errors == 0) begin
            $display("half_float_alu_core: match");
        end else begin
            $display("half_float_alu_core: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ half_float_alu_core.f @@
design/hfa_pkg.sv
design/half_float_alu_core.sv
tb/sv/hfa_checker.sv
tb/sv/tb_half_float_alu_core.sv
